[rtl/core/udc_pkg.sv]
// Shared types, constants and range tables of the UTF-8 decode and classify core.
package udc_pkg;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

    // Lead byte patterns: mask and expected value per sequence length
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_VAL  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_VAL  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_VAL  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_VAL   = 8'h80;
    localparam logic [7:0] ASCII_TOP  = 8'h80;

    typedef enum logic [1:0] {
        CLASS_OTHER  = 2'd0,
        CLASS_LETTER = 2'd1,
        CLASS_DIGIT  = 2'd2,
        CLASS_SPACE  = 2'd3
    } t_class;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } t_in_word;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            malformed;
        logic [1:0]      char_class;
        logic            last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [CP_W-1:0] lo;
        logic [CP_W-1:0] hi;
    } t_span;

    localparam int N_LETTER = 42;
    localparam int N_DIGIT  = 17;
    localparam int N_SPACE  = 10;

    localparam t_span LETTER_SPANS [0:N_LETTER-1] = '{
        '{21'h00041, 21'h0005A}, '{21'h00061, 21'h0007A}, '{21'h00300, 21'h0036F},
        '{21'h00370, 21'h003FF}, '{21'h00400, 21'h0052F}, '{21'h00590, 21'h005FF},
        '{21'h00600, 21'h006FF}, '{21'h00750, 21'h0077F}, '{21'h00900, 21'h009FF},
        '{21'h00A00, 21'h00AFF}, '{21'h00B00, 21'h00BFF}, '{21'h00C00, 21'h00CFF},
        '{21'h00D00, 21'h00DFF}, '{21'h00E00, 21'h00EFF}, '{21'h01000, 21'h0109F},
        '{21'h010A0, 21'h010FF}, '{21'h01100, 21'h011FF}, '{21'h01200, 21'h0137F},
        '{21'h013A0, 21'h013FF}, '{21'h01DC0, 21'h01DFF}, '{21'h01E00, 21'h01EFF},
        '{21'h01F00, 21'h01FFF}, '{21'h020D0, 21'h020FF}, '{21'h02C60, 21'h02C7F},
        '{21'h02E80, 21'h02EFF}, '{21'h03040, 21'h030FF}, '{21'h03130, 21'h0318F},
        '{21'h031A0, 21'h031BF}, '{21'h03400, 21'h04DBF}, '{21'h04E00, 21'h09FFF},
        '{21'h0A000, 21'h0A48F}, '{21'h0AC00, 21'h0D7AF}, '{21'h0F900, 21'h0FAFF},
        '{21'h0FB00, 21'h0FB4F}, '{21'h0FB50, 21'h0FDFF}, '{21'h0FE20, 21'h0FE2F},
        '{21'h0FE70, 21'h0FEFF}, '{21'h0FF21, 21'h0FF3A}, '{21'h0FF41, 21'h0FF5A},
        '{21'h10400, 21'h1044F}, '{21'h1D400, 21'h1D7FF}, '{21'h2F800, 21'h2FA1F}
    };

    localparam t_span DIGIT_SPANS [0:N_DIGIT-1] = '{
        '{21'h00030, 21'h00039}, '{21'h00660, 21'h00669}, '{21'h006F0, 21'h006F9},
        '{21'h00966, 21'h0096F}, '{21'h009E6, 21'h009EF}, '{21'h00A66, 21'h00A6F},
        '{21'h00AE6, 21'h00AEF}, '{21'h00B66, 21'h00B6F}, '{21'h00BE6, 21'h00BEF},
        '{21'h00C66, 21'h00C6F}, '{21'h00CE6, 21'h00CEF}, '{21'h00D66, 21'h00D6F},
        '{21'h00E50, 21'h00E59}, '{21'h00ED0, 21'h00ED9}, '{21'h00F20, 21'h00F29},
        '{21'h0FF10, 21'h0FF19}, '{21'h104A0, 21'h104A9}
    };

    localparam t_span SPACE_SPANS [0:N_SPACE-1] = '{
        '{21'h00009, 21'h0000D}, '{21'h00020, 21'h00020}, '{21'h00085, 21'h00085},
        '{21'h000A0, 21'h000A0}, '{21'h01680, 21'h01680}, '{21'h02000, 21'h0200A},
        '{21'h02028, 21'h02029}, '{21'h0202F, 21'h0202F}, '{21'h0205F, 21'h0205F},
        '{21'h03000, 21'h03000}
    };

    // Letter wins over digit, digit over whitespace
    function automatic t_class classify(input logic [CP_W-1:0] cp);
        logic hit_l;
        logic hit_d;
        logic hit_s;
        hit_l = 1'b0;
        hit_d = 1'b0;
        hit_s = 1'b0;
        for (int i = 0; i < N_LETTER; i++) begin
            if (cp >= LETTER_SPANS[i].lo && cp <= LETTER_SPANS[i].hi) hit_l = 1'b1;
        end
        for (int i = 0; i < N_DIGIT; i++) begin
            if (cp >= DIGIT_SPANS[i].lo && cp <= DIGIT_SPANS[i].hi) hit_d = 1'b1;
        end
        for (int i = 0; i < N_SPACE; i++) begin
            if (cp >= SPACE_SPANS[i].lo && cp <= SPACE_SPANS[i].hi) hit_s = 1'b1;
        end
        if (hit_l)      return CLASS_LETTER;
        else if (hit_d) return CLASS_DIGIT;
        else if (hit_s) return CLASS_SPACE;
        else            return CLASS_OTHER;
    endfunction

    localparam t_class REPL_CLASS = classify(REPLACEMENT);

endpackage

[rtl/core/utf8_decode_classify_core.sv]
// Streaming UTF-8 decoder with replacement and character class tagging.
// Each result passes the decode register, then the classify/output register, before it
//   is offered; while the output stalls, the next result waits in the decode register.
// Throughput: one byte per cycle while each byte yields at most one result and the output
//   is not stalled; a byte with k results (up to 4) holds the output for k handshakes.
// Reset (synchronous, active low) drops any pending sequence and empties both stages.
module utf8_decode_classify_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  udc_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output udc_pkg::t_out_word  o_out_word
);

    // ------------------------------------------------------------------
    // Sequence state: lead plus buffered continuation bytes
    // ------------------------------------------------------------------
    logic [7:0] r_held [0:2];
    logic [1:0] r_held_cnt, n_held_cnt;
    logic [1:0] r_need_cnt, n_need_cnt;

    // Stage 1: result burst descriptor. A burst is (cnt-1) replacements
    // followed by one final word held in cp/bad.
    logic                       r_s1_vld;
    logic [2:0]                 r_s1_cnt;
    logic [udc_pkg::CP_W-1:0]   r_s1_cp;
    logic                       r_s1_bad;

    // Stage 2: classified burst, drained one word per handshake
    logic                       r_s2_vld;
    logic [2:0]                 r_s2_cnt;
    logic [udc_pkg::CP_W-1:0]   r_s2_cp;
    logic                       r_s2_bad;
    logic [1:0]                 r_s2_cls;

    // Decode outputs
    logic                       held_we;
    logic [1:0]                 held_wa;
    logic [2:0]                 dec_reps;
    logic                       dec_fin;
    logic [2:0]                 dec_cnt;
    logic [udc_pkg::CP_W-1:0]   dec_cp;
    logic                       dec_bad;

    logic [7:0]                 in_b;
    logic                       in_eot;
    logic                       accept;
    logic                       s2_take, s2_done, s2_free, s1_move, s1_free;

    assign in_b   = i_in_word.in_byte;
    assign in_eot = i_in_word.end_of_text;

    // ------------------------------------------------------------------
    // Handshake and stage movement
    // ------------------------------------------------------------------
    assign s2_take    = r_s2_vld && i_out_ready;
    assign s2_done    = s2_take && (r_s2_cnt == 3'd1);
    assign s2_free    = !r_s2_vld || s2_done;
    assign s1_move    = r_s1_vld && s2_free;
    assign s1_free    = !r_s1_vld || s1_move;
    assign o_in_ready = s1_free;
    assign accept     = i_in_valid && o_in_ready;

    // ------------------------------------------------------------------
    // Decode: one pass over the incoming byte and the pending state
    // ------------------------------------------------------------------
    always_comb begin
        logic       is_cont;
        logic       lead_path;
        logic [1:0] lead_need;

        is_cont   = (in_b & udc_pkg::CONT_MASK) == udc_pkg::CONT_VAL;
        lead_path = 1'b0;

        if ((in_b & udc_pkg::LEAD2_MASK) == udc_pkg::LEAD2_VAL)      lead_need = 2'd1;
        else if ((in_b & udc_pkg::LEAD3_MASK) == udc_pkg::LEAD3_VAL) lead_need = 2'd2;
        else if ((in_b & udc_pkg::LEAD4_MASK) == udc_pkg::LEAD4_VAL) lead_need = 2'd3;
        else                                                         lead_need = 2'd0;

        n_held_cnt = r_held_cnt;
        n_need_cnt = r_need_cnt;
        held_we    = 1'b0;
        held_wa    = r_held_cnt;
        dec_reps   = 3'd0;
        dec_fin    = 1'b0;
        dec_cp     = udc_pkg::REPLACEMENT;
        dec_bad    = 1'b1;

        if (r_need_cnt == 2'd0) begin
            lead_path = 1'b1;
        end else if (is_cont) begin
            if (r_need_cnt == 2'd1) begin
                // Sequence complete: assemble the code point
                case (r_held_cnt)
                    2'd0: dec_cp = {15'd0, in_b[5:0]};
                    2'd1: dec_cp = {10'd0, r_held[0][4:0], in_b[5:0]};
                    2'd2: dec_cp = {5'd0, r_held[0][3:0], r_held[1][5:0], in_b[5:0]};
                    default: dec_cp = {r_held[0][2:0], r_held[1][5:0], r_held[2][5:0],
                                       in_b[5:0]};
                endcase
                dec_fin    = 1'b1;
                dec_bad    = 1'b0;
                n_held_cnt = 2'd0;
                n_need_cnt = 2'd0;
            end else if (in_eot || r_held_cnt == 2'd3) begin
                // Short at end: flush the held bytes, replace this one too
                dec_reps   = {1'b0, r_held_cnt};
                dec_fin    = 1'b1;
                n_held_cnt = 2'd0;
                n_need_cnt = 2'd0;
            end else begin
                held_we    = 1'b1;
                n_held_cnt = r_held_cnt + 2'd1;
                n_need_cnt = r_need_cnt - 2'd1;
            end
        end else begin
            // Broken sequence: flush, then retry the byte as a lead
            dec_reps   = {1'b0, r_held_cnt};
            n_held_cnt = 2'd0;
            n_need_cnt = 2'd0;
            lead_path  = 1'b1;
        end

        if (lead_path) begin
            if (in_b < udc_pkg::ASCII_TOP) begin
                dec_fin = 1'b1;
                dec_cp  = {13'd0, in_b};
                dec_bad = 1'b0;
            end else if (lead_need == 2'd0 || in_eot) begin
                dec_fin = 1'b1;
            end else begin
                held_we    = 1'b1;
                held_wa    = 2'd0;
                n_held_cnt = 2'd1;
                n_need_cnt = lead_need;
            end
        end

        // Without a final word the burst ends on a replacement, which dec_cp/bad hold
        dec_cnt = dec_reps + {2'd0, dec_fin};
    end

    // ------------------------------------------------------------------
    // Sequence state registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= 2'd0;
            r_need_cnt <= 2'd0;
        end else if (accept) begin
            r_held_cnt <= n_held_cnt;
            r_need_cnt <= n_need_cnt;
        end
    end

    // Held bytes carry payload only; entries above the count are never read
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (accept && held_we && held_wa == 2'(i)) begin
                r_held[i] <= in_b;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: load a burst on accept, drop it when it moves on
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept && dec_cnt != 3'd0) begin
            r_s1_vld <= 1'b1;
        end else if (s1_move) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && dec_cnt != 3'd0) begin
            r_s1_cnt <= dec_cnt;
            r_s1_cp  <= dec_cp;
            r_s1_bad <= dec_bad;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: classify the final word, then count the burst down
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_s2_cnt <= 3'd0;
        end else if (s1_move) begin
            r_s2_vld <= 1'b1;
            r_s2_cnt <= r_s1_cnt;
        end else if (s2_take) begin
            r_s2_cnt <= r_s2_cnt - 3'd1;
            if (s2_done) begin
                r_s2_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_cp  <= r_s1_cp;
            r_s2_bad <= r_s1_bad;
            r_s2_cls <= udc_pkg::classify(r_s1_cp);
        end
    end

    // ------------------------------------------------------------------
    // Output word: replacements first, the stored final word last
    // ------------------------------------------------------------------
    assign o_out_valid = r_s2_vld;

    always_comb begin
        if (r_s2_cnt == 3'd1) begin
            o_out_word.code_point  = r_s2_cp;
            o_out_word.malformed   = r_s2_bad;
            o_out_word.char_class  = r_s2_cls;
            o_out_word.last_of_run = 1'b1;
        end else begin
            o_out_word.code_point  = udc_pkg::REPLACEMENT;
            o_out_word.malformed   = 1'b1;
            o_out_word.char_class  = udc_pkg::REPL_CLASS;
            o_out_word.last_of_run = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_pending_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_need_cnt != 2'd0) |->
            (r_held_cnt != 2'd0) && ({1'b0, r_held_cnt} + {1'b0, r_need_cnt} <= 3'd4))
        else $error("pending sequence state out of range");

    a_s1_burst_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> (r_s1_cnt != 3'd0) && (r_s1_cnt <= 3'd4))
        else $error("stage 1 burst length out of range");

    a_s2_burst_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> (r_s2_cnt != 3'd0) && (r_s2_cnt <= 3'd4))
        else $error("stage 2 burst length out of range");

    a_s2_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_take && r_s2_cnt > 3'd1) |=>
            r_s2_vld && (r_s2_cnt == $past(r_s2_cnt) - 3'd1))
        else $error("burst did not advance by one word");

endmodule
